>>> src/rcmc_pkg.sv
// ----------------------------------------------------------------------------
// rcmc_pkg: shared types and constants of the RGB color matrix converter
// Widths, conversion mode codes and the fixed-point coefficient matrices.
// ----------------------------------------------------------------------------
package rcmc_pkg;

  localparam int CH_W           = 8;
  localparam int COEF_W         = 18;
  localparam int COMP_W         = 18;
  localparam int COEF_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS  = 6;
  localparam int RND_SHIFT      = COEF_FRAC_BITS - OUT_FRAC_BITS;
  localparam int PROD_W         = COEF_W + CH_W + 1;
  localparam int ACC_W          = PROD_W + 2;
  localparam int MODE_W         = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_PASS  = 3'd0,
    MODE_YUV   = 3'd1,
    MODE_LUMA  = 3'd2,
    MODE_YCBCR = 3'd3,
    MODE_OKLAB = 3'd4
  } mode_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    coef_t c_red;
    coef_t c_green;
    coef_t c_blue;
  } coef_row_t;

  typedef struct packed {
    coef_row_t row_first;
    coef_row_t row_second;
    coef_row_t row_third;
  } coef_mat_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  function automatic coef_row_t mk_row(input int a, input int b, input int c);
    coef_row_t r;
    r.c_red   = COEF_W'(a);
    r.c_green = COEF_W'(b);
    r.c_blue  = COEF_W'(c);
    return r;
  endfunction

  // Coefficients with 16 fractional bits, rounded to nearest. The okLab
  // matrix is the product of the RGB-to-LMS and LMS-to-Lab matrices.
  function automatic coef_mat_t mode_matrix(input logic [MODE_W-1:0] mode);
    coef_mat_t m;
    unique case (mode)
      MODE_PASS: begin
        m.row_first  = mk_row(65536, 0, 0);
        m.row_second = mk_row(0, 65536, 0);
        m.row_third  = mk_row(0, 0, 65536);
      end
      MODE_YUV: begin
        m.row_first  = mk_row(19595, 38470, 7471);
        m.row_second = mk_row(-9642, -18931, 28574);
        m.row_third  = mk_row(40305, -33750, -6554);
      end
      MODE_LUMA: begin
        m.row_first  = mk_row(19595, 38470, 7471);
        m.row_second = mk_row(0, 0, 0);
        m.row_third  = mk_row(0, 0, 0);
      end
      MODE_YCBCR: begin
        m.row_first  = mk_row(19595, 38470, 7471);
        m.row_second = mk_row(-11059, -21709, 32768);
        m.row_third  = mk_row(32768, -27439, -5329);
      end
      MODE_OKLAB: begin
        m.row_first  = mk_row(16680, 42726, 6128);
        m.row_second = mk_row(22317, -30503, 8187);
        m.row_third  = mk_row(6888, 20894, -27805);
      end
      default: begin
        m = '0;
      end
    endcase
    return m;
  endfunction

endpackage

>>> src/rcmc_row.sv
// ----------------------------------------------------------------------------
// rcmc_row: one output component of the color matrix
// Three products, their sum, rounding to the output grid and saturation.
// ----------------------------------------------------------------------------
module rcmc_row
  import rcmc_pkg::*;
(
  input  coef_row_t coef,
  input  pixel_t    pix,
  output comp_t     comp
);

  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (RND_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] HALF_LO = HALF - ACC_W'(1);
  localparam int Q_W = ACC_W - RND_SHIFT;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 <<< (COMP_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(1 <<< (COMP_W - 1));

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_g;
  logic signed [PROD_W-1:0] prod_b;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [Q_W-1:0]    quo;

  assign prod_r = PROD_W'(coef.c_red)   * PROD_W'($signed({1'b0, pix.red}));
  assign prod_g = PROD_W'(coef.c_green) * PROD_W'($signed({1'b0, pix.green}));
  assign prod_b = PROD_W'(coef.c_blue)  * PROD_W'($signed({1'b0, pix.blue}));

  assign acc = ACC_W'(prod_r) + ACC_W'(prod_g) + ACC_W'(prod_b);

  // Halves round away from zero: a negative sum gets one less of bias.
  assign rnd = acc + (acc[ACC_W-1] ? HALF_LO : HALF);
  assign quo = Q_W'(rnd >>> RND_SHIFT);

  always_comb begin
    if (quo > Q_MAX) begin
      comp = COMP_W'(Q_MAX);
    end else if (quo < Q_MIN) begin
      comp = COMP_W'(Q_MIN);
    end else begin
      comp = COMP_W'(quo);
    end
  end

endmodule

>>> src/rgb_color_matrix_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_color_matrix_converter_core: streaming RGB to YUV/YCbCr/okLab converter
// Two-stage pixel pipeline with a configuration-selected 3x3 matrix.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and returns one converted pixel per
// pixel, in order. Each pixel is captured in an input register, and three
// row units then multiply it by the active coefficient matrix, round the
// sums to units of 1/64 (halves away from zero) and saturate them into the
// result register. The input register moves on whenever the result
// register has room, so a new pixel is still accepted while a finished
// result waits on the output side as long as the input register is empty;
// with both registers full and the output stalled, the input stalls too.
// While the output does not stall, the sustained rate is one pixel per
// clock, set by the nine coefficient multipliers working in parallel. A
// write on the configuration channel picks the conversion mode (pass-through,
// BT.601 YUV, luma only, YCbCr without offset, okLab as one product of two
// linear matrices; other codes give all-zero results) and loads the
// matching matrix at once. The mode must only be changed while no pixel is
// in flight. After reset the block is in pass-through mode.
module rgb_color_matrix_converter_core
  import rcmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration channel: conversion mode, 3 bits.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  // Pixel input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  // Converted pixel output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [17:0] comp_first, [35:18] comp_second,
                                      // [53:36] comp_third, [55:54] zero
);

  coef_mat_t matrix;
  pixel_t    pix;
  logic      pix_valid;
  logic      res_ready;
  logic      pix_ready;
  comp_t     comp_first;
  comp_t     comp_second;
  comp_t     comp_third;
  comp_t     res_first;
  comp_t     res_second;
  comp_t     res_third;
  logic      res_valid;

  // The channel never stalls: a write simply reloads the matrix.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix <= mode_matrix(MODE_PASS);
    end else if (cfg_valid && cfg_ready) begin
      matrix <= mode_matrix(cfg_data);
    end
  end

  // The result register can take a new value when it is empty or its value
  // is being taken this cycle; the input register likewise.
  assign res_ready     = !res_valid || m_axis_tready;
  assign pix_ready     = !pix_valid || res_ready;
  assign s_axis_tready = pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (pix_ready) begin
      pix_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && pix_ready) begin
      pix <= pixel_t'(s_axis_tdata);
    end
  end

  rcmc_row u_row_first (
    .coef (matrix.row_first),
    .pix  (pix),
    .comp (comp_first)
  );

  rcmc_row u_row_second (
    .coef (matrix.row_second),
    .pix  (pix),
    .comp (comp_second)
  );

  rcmc_row u_row_third (
    .coef (matrix.row_third),
    .pix  (pix),
    .comp (comp_third)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && res_ready) begin
      res_first  <= comp_first;
      res_second <= comp_second;
      res_third  <= comp_third;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {2'b00, res_third, res_second, res_first};

  // An accepted pixel is always held in the input register next cycle.
  a_accept_lands : assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> pix_valid)
    else $error("accepted pixel did not reach the input register");

  // A pixel that cannot move on stays put, unchanged.
  a_pix_holds : assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !res_ready) |=> (pix_valid && $stable(pix)))
    else $error("stalled pixel lost or changed");

  // A pixel that moves on becomes a visible result next cycle.
  a_pix_to_result : assert property (@(posedge clk) disable iff (rst)
    (pix_valid && res_ready) |=> m_axis_tvalid)
    else $error("computed pixel did not reach the result register");

  // The input side never stalls while the pipeline has an empty slot.
  a_no_false_stall : assert property (@(posedge clk) disable iff (rst)
    (!pix_valid || !res_valid) |-> s_axis_tready)
    else $error("input stalled with room in the pipeline");

endmodule

>>> dv/rgb_color_matrix_converter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_color_matrix_converter_core_tb: self-checking bench of the converter
// Streams directed and random pixels through every conversion mode under
// random input gaps and output stalls, predicts each converted pixel with an
// independent fixed-point matrix model and compares it field by field.
// ----------------------------------------------------------------------------
module rgb_color_matrix_converter_core_tb;
  import rcmc_pkg::*;

  // Mode codes that the package leaves without a name; they select an
  // all-zero matrix.
  localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  localparam longint DEC_SCALE   = 100000;
  localparam longint FIVE_POW_15 = 64'd30517578125;
  localparam longint COMP_MAX    = 131071;
  localparam longint COMP_MIN    = -131072;
  localparam int     QUIET_LIMIT = 4000;
  localparam int     PER_MODE    = 77;

  typedef struct {
    comp_t first;
    comp_t second;
    comp_t third;
  } comp_set_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [7:0] red, [15:8] green, [23:16] blue
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // [17:0] first, [35:18] second, [53:36] third

  comp_set_t         expected_pixels[$];
  logic [MODE_W-1:0] active_mode = MODE_PASS;
  int                tx_idle_pct = 29;
  int                rx_idle_pct = 81;
  int                error_count = 0;
  int                quiet_cycles = 0;

  rgb_color_matrix_converter_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Conversion predictor
  // ------------------------------------------------------------------------

  // Division by a positive divisor, nearest, halves away from zero.
  function automatic longint div_nearest(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  // Decimal matrices scaled by 1e5, entries in row-major order.
  function automatic longint decimal_entry(logic [MODE_W-1:0] m, int k);
    longint t [0:8];
    case (m)
      MODE_PASS:  t = '{100000, 0, 0, 0, 100000, 0, 0, 0, 100000};
      MODE_YUV:   t = '{29900, 58700, 11400, -14713, -28886, 43600,
                        61500, -51499, -10001};
      MODE_LUMA:  t = '{29900, 58700, 11400, 0, 0, 0, 0, 0, 0};
      default:    t = '{29900, 58700, 11400, -16874, -33126, 50000,
                        50000, -41869, -8131};
    endcase
    return t[k];
  endfunction

  // RGB to LMS, scaled by 1e10.
  function automatic longint lms_entry(int k);
    longint t [0:8];
    t = '{64'd4121656120, 64'd5362752080, 64'd514575653,
          64'd2118591070, 64'd6807189584, 64'd1074065790,
          64'd883097947,  64'd2818474174, 64'd6302613616};
    return t[k];
  endfunction

  // LMS to Lab, scaled by 1e10.
  function automatic longint lab_entry(int k);
    longint t [0:8];
    t = '{64'd2104542553,  64'd7936177850,   -64'sd40720468,
          64'd19779984951, -64'sd24285922050, 64'd4505937099,
          64'd259040371,   64'd7827717662,   -64'sd8086757660};
    return t[k];
  endfunction

  // One okLab coefficient: the two 1e10-scaled matrices are multiplied in
  // two halves so the exact product fits 64 bits, then scaled down to the
  // coefficient grid in one rounding step.
  function automatic longint oklab_coef(int row, int col);
    longint hi, lo, q, r, t;
    hi = 0;
    lo = 0;
    for (int k = 0; k < 3; k++) begin
      q  = lab_entry(row * 3 + k) / 100000;
      r  = lab_entry(row * 3 + k) - q * 100000;
      hi += q * lms_entry(k * 3 + col);
      lo += r * lms_entry(k * 3 + col);
    end
    t = hi * 512 + (lo * 16) / 3125;
    return div_nearest(t, FIVE_POW_15 * (longint'(1) << (24 - COEF_FRAC_BITS)));
  endfunction

  function automatic longint matrix_coef(logic [MODE_W-1:0] m, int row, int col);
    case (m)
      MODE_PASS, MODE_YUV, MODE_LUMA, MODE_YCBCR:
        return div_nearest(decimal_entry(m, row * 3 + col) *
                           (longint'(1) << COEF_FRAC_BITS), DEC_SCALE);
      MODE_OKLAB:
        return oklab_coef(row, col);
      default:
        return 0;
    endcase
  endfunction

  function automatic comp_set_t convert_pixel(logic [MODE_W-1:0] m, logic [23:0] px);
    longint    chan [0:2];
    longint    acc, v;
    comp_t     comp [0:2];
    comp_set_t res;
    chan[0] = px[7:0];
    chan[1] = px[15:8];
    chan[2] = px[23:16];
    for (int row = 0; row < 3; row++) begin
      acc = 0;
      for (int col = 0; col < 3; col++) acc += matrix_coef(m, row, col) * chan[col];
      v = div_nearest(acc, longint'(1) << RND_SHIFT);
      if (v > COMP_MAX) v = COMP_MAX;
      if (v < COMP_MIN) v = COMP_MIN;
      comp[row] = comp_t'(v);
    end
    res.first  = comp[0];
    res.second = comp[1];
    res.third  = comp[2];
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Sends one pixel request. Before each pixel the sender idles cycle by
  // cycle with the chosen percentage; otherwise valid stays high from one
  // pixel to the next.
  task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blue, green, red};
    do @(posedge clk); while (!s_axis_tready);
    expected_pixels.push_back(convert_pixel(active_mode, {blue, green, red}));
  endtask

  // Channel values lean toward the ends of the range now and then.
  task automatic send_random_pixel();
    logic [7:0] chan [0:2];
    int         pick;
    for (int i = 0; i < 3; i++) begin
      pick = $urandom_range(9);
      chan[i] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
    end
    send_pixel(chan[0], chan[1], chan[2]);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // The mode changes only with nothing in flight.
  task automatic write_mode(logic [MODE_W-1:0] m);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    active_mode = m;
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Pass-through must be active straight out of reset.
  task automatic test_reset_mode();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'hAA);
  endtask

  // Extremes in each of the other modes, the unnamed codes included.
  task automatic test_each_mode();
    logic [MODE_W-1:0] modes [0:6];
    modes = '{MODE_YUV, MODE_LUMA, MODE_YCBCR, MODE_OKLAB,
              MODE_RSVD5, MODE_RSVD6, MODE_RSVD7};
    foreach (modes[i]) begin
      write_mode(modes[i]);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);
    end
  endtask

  task automatic test_random_stream(int tx_pct, int rx_pct);
    logic [MODE_W-1:0] modes [0:7];
    modes = '{MODE_PASS, MODE_OKLAB, MODE_RSVD7, MODE_YUV,
              MODE_YCBCR, MODE_RSVD5, MODE_LUMA, MODE_RSVD6};
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    foreach (modes[i]) begin
      write_mode(modes[i]);
      repeat (PER_MODE) send_random_pixel();
    end
  endtask

  // Short bursts, each followed by a pause until the pipeline is empty.
  task automatic test_drain_pause();
    write_mode(MODE_YUV);
    repeat (4) begin
      repeat (5) send_random_pixel();
      wait_drained();
    end
  endtask

  // ------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ------------------------------------------------------------------------

  always @(posedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic compare_field(string name, comp_t exp_val, comp_t act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d",
               $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    comp_set_t exp_set;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h",
                 $time, m_axis_tdata);
        error_count++;
      end else begin
        exp_set = expected_pixels.pop_front();
        compare_field("comp_first",  exp_set.first,  m_axis_tdata[17:0]);
        compare_field("comp_second", exp_set.second, m_axis_tdata[35:18]);
        compare_field("comp_third",  exp_set.third,  m_axis_tdata[53:36]);
      end
    end
  end

  // Any accepted request on any channel counts as progress.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rgb_color_matrix_converter_core_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_mode();
    test_each_mode();
    test_random_stream(29, 81);
    test_drain_pause();
    test_random_stream(81, 29);
    test_random_stream(0, 0);
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("rgb_color_matrix_converter_core_tb: PASS");
    end else begin
      $display("rgb_color_matrix_converter_core_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/rcmc_pkg.sv
src/rcmc_row.sv
src/rgb_color_matrix_converter_core.sv
dv/rgb_color_matrix_converter_core_tb.sv
